### hdl/rsq_pkg.sv
// shared types, constants and helper functions for the rotated sprite quad setup block
`default_nettype none
package rsq_pkg;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [11:0] size_w;
        logic        [11:0] size_h;
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_a;
        logic        [11:0] scale_x;
        logic        [11:0] scale_y;
        logic        [15:0] texture_id;
        logic        [31:0] color;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               tex_u;
        logic               tex_v;
        logic        [31:0] vertex_color;
        logic        [15:0] vertex_texture;
        logic               starts_batch;
        logic               last_vertex;
    } t_out_item;

    localparam int MUL_A_W   = 29;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 45;
    localparam int SUM_W     = 46;
    localparam int RND_SHIFT = 22;
    localparam int POS_W     = 16;
    localparam int N_STEPS   = 8;
    localparam int STEP_W    = $clog2(N_STEPS);
    localparam int N_VERTS   = 6;
    localparam int VTX_W     = $clog2(N_VERTS);
    localparam int N_CORNERS = 4;
    localparam int CORNER_W  = $clog2(N_CORNERS);

    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

    typedef logic signed [PROD_W-1:0] t_prod;

    // two triangles: corners 0,1,3 then 3,1,2
    function automatic logic [CORNER_W-1:0] vertex_corner(input logic [VTX_W-1:0] k);
        logic [CORNER_W-1:0] c;
        case (k)
            3'd0:    c = CORNER_TL;
            3'd1:    c = CORNER_TR;
            3'd2:    c = CORNER_BL;
            3'd3:    c = CORNER_BL;
            3'd4:    c = CORNER_TR;
            3'd5:    c = CORNER_BR;
            default: c = CORNER_TL;
        endcase
        return c;
    endfunction

    function automatic logic corner_right(input logic [CORNER_W-1:0] c);
        return (c == CORNER_TR) || (c == CORNER_BR);
    endfunction

    function automatic logic corner_bottom(input logic [CORNER_W-1:0] c);
        return (c == CORNER_BR) || (c == CORNER_BL);
    endfunction

endpackage
`default_nettype wire

### hdl/rsq_mul.sv
// shared signed multiplier used for every scale and rotation product
`default_nettype none
module rsq_mul (
    input  wire logic signed [rsq_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [rsq_pkg::MUL_B_W-1:0] i_b,
    output logic signed [rsq_pkg::PROD_W-1:0]       o_p
);
    import rsq_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] full;

    assign full = i_a * i_b;
    assign o_p  = full[PROD_W-1:0];

endmodule
`default_nettype wire

### hdl/rsq_corner.sv
// corner position: signed offset sums, round to q.4, add center, saturate
`default_nettype none
module rsq_corner (
    input  wire rsq_pkg::t_prod                       i_a,
    input  wire rsq_pkg::t_prod                       i_b,
    input  wire rsq_pkg::t_prod                       i_c,
    input  wire rsq_pkg::t_prod                       i_d,
    input  wire logic                                 i_right,
    input  wire logic                                 i_bottom,
    input  wire logic signed [rsq_pkg::POS_W-1:0]     i_center_x,
    input  wire logic signed [rsq_pkg::POS_W-1:0]     i_center_y,
    output logic signed [rsq_pkg::POS_W-1:0]          o_pos_x,
    output logic signed [rsq_pkg::POS_W-1:0]          o_pos_y
);
    import rsq_pkg::*;

    localparam int RND_W = SUM_W - RND_SHIFT;
    localparam int CEN_W = RND_W + 1;

    logic signed [SUM_W-1:0] ext_a, ext_b, ext_c, ext_d, bias;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [CEN_W-1:0] full_x, full_y;

    function automatic logic signed [POS_W-1:0] sat(input logic signed [CEN_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v[CEN_W-1:POS_W-1] == '0 || v[CEN_W-1:POS_W-1] == '1) begin
            r = v[POS_W-1:0];
        end else if (v[CEN_W-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb begin
        ext_a = SUM_W'(i_a);
        ext_b = SUM_W'(i_b);
        ext_c = SUM_W'(i_c);
        ext_d = SUM_W'(i_d);
        bias  = SUM_W'(1) <<< (RND_SHIFT - 1);
        sum_x = (i_right ? ext_a : -ext_a) + (i_bottom ? ext_b : -ext_b) + bias;
        sum_y = (i_bottom ? ext_c : -ext_c) + (i_right ? -ext_d : ext_d) + bias;
        full_x = CEN_W'(signed'(sum_x[SUM_W-1:RND_SHIFT])) + CEN_W'(i_center_x);
        full_y = CEN_W'(signed'(sum_y[SUM_W-1:RND_SHIFT])) + CEN_W'(i_center_y);
        o_pos_x = sat(full_x);
        o_pos_y = sat(full_y);
    end

endmodule
`default_nettype wire

### hdl/rotated_sprite_quad_setup.sv
// top level: sequencer, product registers and vertex output register
// Turns one sprite draw into six vertices (two triangles, corners 0,1,3 and 3,1,2)
// with corner UVs, color and texture. An accepted item with a nonzero texture
// runs its scale and rotation products through one shared 29x17 multiplier,
// then emits one vertex per cycle through an output register while the output
// side does not stall; the input is ready only between items. A texture id of
// zero is accepted and produces nothing.
// starts_batch marks the first vertex whenever the texture differs from the last
// one drawn (or none has been drawn since reset).
`default_nettype none
module rotated_sprite_quad_setup (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rsq_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rsq_pkg::t_out_item     o_out_item
);
    import rsq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [VTX_W-1:0]  r_vtx, n_vtx;
    logic [15:0]       r_cur_tex, n_cur_tex;
    logic              r_tex_valid, n_tex_valid;
    logic              r_first, n_first;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    t_in_item          r_item;
    t_prod             r_prod [N_CORNERS];

    logic                       accept;
    logic signed [15:0]         trig;
    logic                       use_y;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    t_prod                      mul_p;
    logic [CORNER_W-1:0]        corner;
    logic                       right, bottom;
    logic signed [POS_W-1:0]    pos_x, pos_y;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // steps 0..3: trig * scale, steps 4..7: that product * half size
    always_comb begin
        trig  = r_step[0] ? r_item.sin_a : r_item.cos_a;
        use_y = r_step[0] ^ r_step[1];
        if (r_step[2]) begin
            mul_a = r_prod[r_step[1:0]][MUL_A_W-1:0];
            mul_b = use_y ? MUL_B_W'({r_item.size_h, 3'b000})
                          : MUL_B_W'({r_item.size_w, 3'b000});
        end else begin
            mul_a = MUL_A_W'(trig);
            mul_b = use_y ? MUL_B_W'(r_item.scale_y) : MUL_B_W'(r_item.scale_x);
        end
    end

    rsq_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    assign corner = vertex_corner(r_vtx);
    assign right  = corner_right(corner);
    assign bottom = corner_bottom(corner);

    rsq_corner u_corner (
        .i_a        (r_prod[0]),
        .i_b        (r_prod[1]),
        .i_c        (r_prod[2]),
        .i_d        (r_prod[3]),
        .i_right    (right),
        .i_bottom   (bottom),
        .i_center_x (r_item.center_x),
        .i_center_y (r_item.center_y),
        .o_pos_x    (pos_x),
        .o_pos_y    (pos_y)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_vtx       = r_vtx;
        n_cur_tex   = r_cur_tex;
        n_tex_valid = r_tex_valid;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in_item.texture_id != '0) begin
                    n_first     = !r_tex_valid || (r_cur_tex != i_in_item.texture_id);
                    n_cur_tex   = i_in_item.texture_id;
                    n_tex_valid = 1'b1;
                    n_step      = '0;
                    n_state     = ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(N_STEPS - 1)) begin
                    n_vtx   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.pos_x          = pos_x;
                    n_out.pos_y          = pos_y;
                    n_out.tex_u          = right;
                    n_out.tex_v          = bottom;
                    n_out.vertex_color   = r_item.color;
                    n_out.vertex_texture = r_item.texture_id;
                    n_out.starts_batch   = (r_vtx == '0) && r_first;
                    n_out.last_vertex    = (r_vtx == VTX_W'(N_VERTS - 1));
                    n_vtx                = r_vtx + VTX_W'(1);
                    if (r_vtx == VTX_W'(N_VERTS - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_vtx       <= '0;
            r_cur_tex   <= '0;
            r_tex_valid <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_vtx       <= n_vtx;
            r_cur_tex   <= n_cur_tex;
            r_tex_valid <= n_tex_valid;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_item <= i_in_item;
        end
        if (r_state == ST_MUL) begin
            r_prod[r_step[1:0]] <= mul_p;
        end
    end

    a_zero_tex_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.texture_id == '0) |=> (r_state == ST_IDLE))
        else $error("texture zero item started a quad");

    a_mul_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_step != STEP_W'(N_STEPS - 1)) |=> (r_state == ST_MUL))
        else $error("multiply sequence cut short");

    a_tex_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_tex_valid))
        else $error("kept texture lost");

    a_batch_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.starts_batch) |-> !o_out_item.last_vertex)
        else $error("batch start on last vertex");

endmodule
`default_nettype wire
